// ===== rtl/core/pipu_pkg.sv =====
// Shared types and constants for the palette-indexed pixel upscaler.
// Depends on nothing; pipu_pos, pipu_gen and the top level refer to it by scoped names.
package pipu_pkg;

	// Coordinate width that covers every destination size up to 4096
	localparam int CRD_W = 13;

	// Palette geometry
	localparam int PAL_DEPTH = 256;
	localparam int PAL_AW    = 8;
	localparam int RGB_W     = 24;

	// Write budget per source pixel
	localparam int MAX_WRITES = 16;
	localparam int CNT_W      = 4;

	// Opaque alpha byte
	localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

	// Input transaction kinds
	localparam logic KIND_PIXEL   = 1'b0;
	localparam logic KIND_PALETTE = 1'b1;

	typedef struct packed {
		logic       kind;
		logic       frame_start;
		logic [7:0] pixel_index;
		logic [7:0] palette_slot;
		logic [7:0] palette_red;
		logic [7:0] palette_green;
		logic [7:0] palette_blue;
	} in_t;

	typedef struct packed {
		logic [10:0] dest_x;
		logic [9:0]  dest_y;
		logic [31:0] argb_color;
		logic        block_last;
	} out_t;

	// Destination block covered by one source pixel
	typedef struct packed {
		logic [CRD_W-1:0] x0;
		logic [CRD_W-1:0] y0;
		logic [CRD_W-1:0] y1m1;
		logic             empty;
	} blk_t;

endpackage

// ===== rtl/core/pipu_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module pipu_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read, data held while not enabled
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== rtl/core/pipu_pos.sv =====
// Source position tracker: column, row and the destination block they map to.
// Depends on pipu_pkg (blk_t, CRD_W).
module pipu_pos #(
	parameter int SOURCE_WIDTH  = 320,
	parameter int SOURCE_HEIGHT = 200,
	parameter int DEST_HEIGHT   = 720,
	parameter int RATIO         = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           advance,
	input  logic           frame_start,
	output pipu_pkg::blk_t blk
);

	localparam int COL_W = $clog2(SOURCE_WIDTH + 1);
	localparam int ROW_W = $clog2(SOURCE_HEIGHT + 1);
	localparam int SUM_W = ROW_W + 1;
	localparam int YQ    = DEST_HEIGHT / SOURCE_HEIGHT;
	localparam int YR    = DEST_HEIGHT % SOURCE_HEIGHT;

	logic [COL_W-1:0]          col_q, eff_col, col_nx;
	logic [ROW_W-1:0]          row_q, eff_row, row_nx;
	logic [pipu_pkg::CRD_W-1:0] x0_q, eff_x0;
	logic [pipu_pkg::CRD_W-1:0] y0_q, eff_y0, y1;
	logic [ROW_W-1:0]          rem_q, eff_rem, rem_nx;
	logic [SUM_W-1:0]          rem_sum;
	logic                      carry, col_wrap, row_wrap;

	// Start of frame overrides the stored position
	always_comb begin
		eff_col = frame_start ? '0 : col_q;
		eff_row = frame_start ? '0 : row_q;
		eff_x0  = frame_start ? '0 : x0_q;
		eff_y0  = frame_start ? '0 : y0_q;
		eff_rem = frame_start ? '0 : rem_q;
	end

	// Row span end: y1 = y0 + quotient + carry of the running remainder
	always_comb begin
		rem_sum = {1'b0, eff_rem} + SUM_W'(YR);
		carry   = rem_sum >= SUM_W'(SOURCE_HEIGHT);
		rem_nx  = carry ? ROW_W'(rem_sum - SUM_W'(SOURCE_HEIGHT)) : ROW_W'(rem_sum);
		y1      = eff_y0 + pipu_pkg::CRD_W'(YQ) + pipu_pkg::CRD_W'(carry);
	end

	// Block for the pixel being accepted
	always_comb begin
		blk.x0    = eff_x0;
		blk.y0    = eff_y0;
		blk.y1m1  = y1 - pipu_pkg::CRD_W'(1);
		blk.empty = (RATIO == 0) || (y1 == eff_y0);
	end

	always_comb begin
		col_nx   = eff_col + COL_W'(1);
		row_nx   = eff_row + ROW_W'(1);
		col_wrap = col_nx == COL_W'(SOURCE_WIDTH);
		row_wrap = row_nx == ROW_W'(SOURCE_HEIGHT);
	end

	// Advance column, then row, then wrap the frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			x0_q  <= '0;
			y0_q  <= '0;
			rem_q <= '0;
		end else if (advance) begin
			if (!col_wrap) begin
				col_q <= col_nx;
				row_q <= eff_row;
				x0_q  <= eff_x0 + pipu_pkg::CRD_W'(RATIO);
				y0_q  <= eff_y0;
				rem_q <= eff_rem;
			end else if (!row_wrap) begin
				col_q <= '0;
				row_q <= row_nx;
				x0_q  <= '0;
				y0_q  <= y1;
				rem_q <= rem_nx;
			end else begin
				col_q <= '0;
				row_q <= '0;
				x0_q  <= '0;
				y0_q  <= '0;
				rem_q <= '0;
			end
		end
	end

endmodule

// ===== rtl/core/pipu_gen.sv =====
// Write generator: walks one destination block, one pixel write per cycle while the output is not stalled.
// Depends on pipu_pkg (blk_t, out_t, widths, write budget).
module pipu_gen #(
	parameter int RATIO = 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         load,
	input  pipu_pkg::blk_t               blk,
	input  logic [pipu_pkg::RGB_W-1:0]   color,
	output logic                         free,
	output logic                         dst_valid,
	input  logic                         dst_stall,
	output pipu_pkg::out_t               dst_item
);

	logic                        vld_q;
	logic [pipu_pkg::CRD_W-1:0]  x0_q, x_q, y_q, y1m1_q, s_q;
	logic [pipu_pkg::CNT_W-1:0]  cnt_q;
	logic [pipu_pkg::RGB_W-1:0]  color_q;
	logic                        row_end, last, fire;

	always_comb begin
		row_end = s_q == pipu_pkg::CRD_W'(RATIO - 1);
		last    = (cnt_q == pipu_pkg::CNT_W'(pipu_pkg::MAX_WRITES - 1))
			|| (row_end && (y_q == y1m1_q));
		fire    = vld_q && !dst_stall;
		free    = !vld_q || (fire && last);
	end

	// Present the current write
	always_comb begin
		dst_valid           = vld_q;
		dst_item.dest_x     = x_q[10:0];
		dst_item.dest_y     = y_q[9:0];
		dst_item.argb_color = {pipu_pkg::ALPHA_OPAQUE, color_q};
		dst_item.block_last = last;
	end

	// Control: load a block, drop it after its last transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (load) begin
			vld_q <= 1'b1;
		end else if (fire && last) begin
			vld_q <= 1'b0;
		end
	end

	// Walk left to right, then down
	always_ff @(posedge clk) begin
		if (load) begin
			x0_q    <= blk.x0;
			x_q     <= blk.x0;
			y_q     <= blk.y0;
			y1m1_q  <= blk.y1m1;
			s_q     <= '0;
			cnt_q   <= '0;
			color_q <= color;
		end else if (fire && !last) begin
			cnt_q <= cnt_q + pipu_pkg::CNT_W'(1);
			if (row_end) begin
				s_q <= '0;
				x_q <= x0_q;
				y_q <= y_q + pipu_pkg::CRD_W'(1);
			end else begin
				s_q <= s_q + pipu_pkg::CRD_W'(1);
				x_q <= x_q + pipu_pkg::CRD_W'(1);
			end
		end
	end

endmodule

// ===== rtl/core/palette_indexed_pixel_upscaler.sv =====
// Palette-indexed pixel upscaler: palette lookup and nearest-neighbor block writes.
// The first write of a pixel comes from the write generator once the pixel has left stage 1.
// A pixel expands to min(16, ratio * row span) writes (12 or 16 at default sizes), one write
// per cycle while the output is not stalled; the next pixel can wait in stage 1 meanwhile.
// Reset: asynchronous; palette reads as the grey ramp and position returns to 0,0.
// Depends on pipu_pkg, pipu_ram, pipu_pos, pipu_gen.
module palette_indexed_pixel_upscaler #(
	parameter int SOURCE_WIDTH  = 320,
	parameter int SOURCE_HEIGHT = 200,
	parameter int DEST_WIDTH    = 1280,
	parameter int DEST_HEIGHT   = 720
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           src_valid,
	output logic           src_stall,
	input  pipu_pkg::in_t  src_item,
	output logic           dst_valid,
	input  logic           dst_stall,
	output pipu_pkg::out_t dst_item
);

	localparam int RATIO = DEST_WIDTH / SOURCE_WIDTH;

	logic                          src_fire, pix_fire, pal_fire;
	logic [pipu_pkg::PAL_DEPTH-1:0] pal_ok_q;
	logic [pipu_pkg::RGB_W-1:0]    rd_data, color_s1;
	pipu_pkg::blk_t                blk, blk_s1;
	logic                          valid_s1, pal_ok_s1, adv_s1, load, gen_free;
	logic [pipu_pkg::PAL_AW-1:0]   idx_s1;

	// Accept into stage 1 when it is empty or moving on
	always_comb begin
		adv_s1    = valid_s1 && (blk_s1.empty || gen_free);
		load      = valid_s1 && !blk_s1.empty && gen_free;
		src_stall = valid_s1 && !adv_s1;
		src_fire  = src_valid && !src_stall;
		pix_fire  = src_fire && (src_item.kind == pipu_pkg::KIND_PIXEL);
		pal_fire  = src_fire && (src_item.kind == pipu_pkg::KIND_PALETTE);
	end

	pipu_ram #(
		.WIDTH(pipu_pkg::RGB_W),
		.DEPTH(pipu_pkg::PAL_DEPTH)
	) u_palette (
		.clk     (clk),
		.wr_en   (pal_fire),
		.wr_addr (src_item.palette_slot),
		.wr_data ({src_item.palette_red, src_item.palette_green, src_item.palette_blue}),
		.rd_en   (pix_fire),
		.rd_addr (src_item.pixel_index),
		.rd_data (rd_data)
	);

	// Mark written palette entries; unwritten ones read as the grey ramp
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pal_ok_q <= '0;
		end else if (pal_fire) begin
			pal_ok_q[src_item.palette_slot] <= 1'b1;
		end
	end

	pipu_pos #(
		.SOURCE_WIDTH  (SOURCE_WIDTH),
		.SOURCE_HEIGHT (SOURCE_HEIGHT),
		.DEST_HEIGHT   (DEST_HEIGHT),
		.RATIO         (RATIO)
	) u_pos (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (pix_fire),
		.frame_start (src_item.frame_start),
		.blk         (blk)
	);

	// Stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pix_fire) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// Stage 1 payload, captured alongside the palette read
	always_ff @(posedge clk) begin
		if (pix_fire) begin
			blk_s1    <= blk;
			idx_s1    <= src_item.pixel_index;
			pal_ok_s1 <= pal_ok_q[src_item.pixel_index];
		end
	end

	assign color_s1 = pal_ok_s1 ? rd_data : {idx_s1, idx_s1, idx_s1};

	pipu_gen #(
		.RATIO(RATIO)
	) u_gen (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.blk       (blk_s1),
		.color     (color_s1),
		.free      (gen_free),
		.dst_valid (dst_valid),
		.dst_stall (dst_stall),
		.dst_item  (dst_item)
	);

endmodule

// ===== dv/palette_indexed_pixel_upscaler_checker.sv =====
`timescale 1ns / 1ps
// Checker for the palette-indexed pixel upscaler: tracks the palette and source position,
// expands each accepted pixel into its destination writes and compares the output stream.
// Depends on pipu_pkg for the transaction types and constants.
module palette_indexed_pixel_upscaler_checker #(
	parameter int SOURCE_WIDTH  = 320,
	parameter int SOURCE_HEIGHT = 200,
	parameter int DEST_WIDTH    = 1280,
	parameter int DEST_HEIGHT   = 720
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           src_valid,
	input  logic           src_stall,
	input  pipu_pkg::in_t  src_item,
	input  logic           dst_valid,
	input  logic           dst_stall,
	input  pipu_pkg::out_t dst_item,
	output int             fail_count,
	output int             outstanding
);

	// Shadow state of the block
	logic [23:0] palette [pipu_pkg::PAL_DEPTH];
	logic [8:0]  column;
	logic [7:0]  row;

	// Destination writes predicted but not yet seen, oldest first
	pipu_pkg::out_t block_writes [$];
	pipu_pkg::out_t want;

	// Expand one source pixel into its destination block, then advance the position
	function automatic void upscale_pixel(input pipu_pkg::in_t px);
		int          ratio;
		int          y_lo;
		int          y_hi;
		int          total;
		int          n;
		logic [31:0] xw;
		logic [31:0] yw;
		logic [31:0] argb;
		pipu_pkg::out_t w;
		if (px.frame_start) begin
			column = '0;
			row = '0;
		end
		ratio = DEST_WIDTH / SOURCE_WIDTH;
		y_lo = (int'(row) * DEST_HEIGHT) / SOURCE_HEIGHT;
		y_hi = ((int'(row) + 1) * DEST_HEIGHT) / SOURCE_HEIGHT;
		total = (y_hi > y_lo) ? ratio * (y_hi - y_lo) : 0;
		if (total > pipu_pkg::MAX_WRITES)
			total = pipu_pkg::MAX_WRITES;
		argb = {pipu_pkg::ALPHA_OPAQUE, palette[px.pixel_index]};
		n = 0;
		// Row by row, left to right, capped at the write budget
		for (int dy = y_lo; dy < y_hi && n < pipu_pkg::MAX_WRITES; dy++) begin
			for (int s = 0; s < ratio && n < pipu_pkg::MAX_WRITES; s++) begin
				xw = int'(column) * ratio + s;
				yw = dy;
				w.dest_x = xw[10:0];
				w.dest_y = yw[9:0];
				w.argb_color = argb;
				w.block_last = (n == total - 1);
				block_writes.push_back(w);
				n++;
			end
		end
		// Wrap at end of line and end of frame
		if (int'(column) + 1 >= SOURCE_WIDTH) begin
			column = '0;
			if (int'(row) + 1 >= SOURCE_HEIGHT)
				row = '0;
			else
				row = row + 8'd1;
		end else begin
			column = column + 9'd1;
		end
	endfunction

	// Compare outgoing transactions first, then fold in the incoming one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < pipu_pkg::PAL_DEPTH; i++)
				palette[i] = {i[7:0], i[7:0], i[7:0]};
			column = '0;
			row = '0;
			block_writes.delete();
			fail_count = 0;
			outstanding = 0;
		end else begin
			if (dst_valid && !dst_stall) begin
				if (block_writes.size() == 0) begin
					if (fail_count < 10)
						$display("%0t: write with nothing pending: x=%0d y=%0d argb=%08h last=%0b",
							$realtime, dst_item.dest_x, dst_item.dest_y, dst_item.argb_color,
							dst_item.block_last);
					fail_count++;
				end else begin
					want = block_writes.pop_front();
					if (dst_item.dest_x !== want.dest_x || dst_item.dest_y !== want.dest_y ||
						dst_item.argb_color !== want.argb_color ||
						dst_item.block_last !== want.block_last) begin
						if (fail_count < 10) begin
							$display("%0t: mismatch expected x=%0d y=%0d argb=%08h last=%0b",
								$realtime, want.dest_x, want.dest_y, want.argb_color,
								want.block_last);
							$display("%0t:          actual   x=%0d y=%0d argb=%08h last=%0b",
								$realtime, dst_item.dest_x, dst_item.dest_y,
								dst_item.argb_color, dst_item.block_last);
						end
						fail_count++;
					end
				end
			end
			if (src_valid && !src_stall) begin
				if (src_item.kind == pipu_pkg::KIND_PALETTE)
					palette[src_item.palette_slot] = {src_item.palette_red,
						src_item.palette_green, src_item.palette_blue};
				else
					upscale_pixel(src_item);
			end
			outstanding = block_writes.size();
		end
	end

endmodule

// ===== dv/palette_indexed_pixel_upscaler_tb.sv =====
`timescale 1ns / 1ps
// Top of the upscaler testbench: clock, reset, source and sink traffic with random idling.
// Depends on pipu_pkg, the upscaler RTL and palette_indexed_pixel_upscaler_checker.
module palette_indexed_pixel_upscaler_tb;

	localparam int SRC_W = 320;
	localparam int SRC_H = 200;
	localparam int DST_W = 1280;
	localparam int DST_H = 720;

	logic           clk;
	logic           arst_n;
	logic           src_valid;
	logic           src_stall;
	pipu_pkg::in_t  src_item;
	logic           dst_valid;
	logic           dst_stall;
	pipu_pkg::out_t dst_item;
	int             fail_count;
	int             outstanding;
	logic           no_idle;

	palette_indexed_pixel_upscaler #(
		.SOURCE_WIDTH (SRC_W),
		.SOURCE_HEIGHT(SRC_H),
		.DEST_WIDTH   (DST_W),
		.DEST_HEIGHT  (DST_H)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.src_valid(src_valid),
		.src_stall(src_stall),
		.src_item (src_item),
		.dst_valid(dst_valid),
		.dst_stall(dst_stall),
		.dst_item (dst_item)
	);

	palette_indexed_pixel_upscaler_checker #(
		.SOURCE_WIDTH (SRC_W),
		.SOURCE_HEIGHT(SRC_H),
		.DEST_WIDTH   (DST_W),
		.DEST_HEIGHT  (DST_H)
	) checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.src_valid  (src_valid),
		.src_stall  (src_stall),
		.src_item   (src_item),
		.dst_valid  (dst_valid),
		.dst_stall  (dst_stall),
		.dst_item   (dst_item),
		.fail_count (fail_count),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Idle cycles before a transaction, none during a burst stretch
	function automatic int draw_wait();
		return no_idle ? 0 : $urandom_range(0, 12);
	endfunction

	// Random fill for every field of an input transaction
	function automatic pipu_pkg::in_t rand_item();
		logic [63:0] rnd;
		rnd = {$urandom, $urandom};
		return rnd[$bits(pipu_pkg::in_t)-1:0];
	endfunction

	// Offer one transaction from a falling edge and return at the falling edge after acceptance
	task automatic send_item(input pipu_pkg::in_t it);
		int gap;
		gap = draw_wait();
		if (gap > 0) begin
			src_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		src_valid <= 1'b1;
		src_item <= it;
		do @(posedge clk); while (!(src_valid && !src_stall));
		@(negedge clk);
	endtask

	task automatic send_pixel(input logic [7:0] idx, input logic fs);
		pipu_pkg::in_t it;
		it = rand_item();
		it.kind = pipu_pkg::KIND_PIXEL;
		it.frame_start = fs;
		it.pixel_index = idx;
		send_item(it);
	endtask

	task automatic send_palette(input logic [7:0] slot, input logic [7:0] r,
		input logic [7:0] g, input logic [7:0] b, input logic fs);
		pipu_pkg::in_t it;
		it = rand_item();
		it.kind = pipu_pkg::KIND_PALETTE;
		it.frame_start = fs;
		it.palette_slot = slot;
		it.palette_red = r;
		it.palette_green = g;
		it.palette_blue = b;
		send_item(it);
	endtask

	// Sink: stall a random number of cycles before each write, then take it
	initial begin
		int hold;
		dst_stall = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			hold = draw_wait();
			if (hold > 0) begin
				dst_stall <= 1'b1;
				repeat (hold) @(negedge clk);
			end
			dst_stall <= 1'b0;
			do @(posedge clk); while (!(dst_valid && !dst_stall));
			@(negedge clk);
		end
	end

	// Stimulus and verdict
	initial begin
		pipu_pkg::in_t it;
		int            run;
		arst_n = 1'b0;
		src_valid = 1'b0;
		src_item = '0;
		no_idle = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: grey ramp extremes, palette extremes, restart mid-row, ignored fields
		send_pixel(8'h00, 1'b1);
		send_pixel(8'hFF, 1'b0);
		send_palette(8'h00, 8'hFF, 8'hFF, 8'hFF, 1'b0);
		send_palette(8'hFF, 8'h00, 8'h00, 8'h00, 1'b0);
		send_palette(8'h5A, 8'hA5, 8'h3C, 8'hC3, 1'b1);
		send_pixel(8'h00, 1'b0);
		send_pixel(8'hFF, 1'b0);
		send_pixel(8'h5A, 1'b0);
		send_palette(8'h80, 8'h01, 8'h80, 8'hFE, 1'b0);
		send_pixel(8'h80, 1'b1);
		send_pixel(8'h7F, 1'b0);
		send_palette(8'h01, 8'hFF, 8'h00, 8'hFF, 1'b1);
		send_pixel(8'h01, 1'b0);
		send_palette(8'h01, 8'h00, 8'hFF, 8'h00, 1'b0);
		send_pixel(8'h01, 1'b0);
		send_pixel(8'hAA, 1'b0);
		send_pixel(8'h55, 1'b0);

		// Pixels sent since the last frame start above
		run = 6;

		// Random: no frame start until the position has crossed the end of a line
		for (int i = 0; i < 335; i++) begin
			if (i % 32 == 0)
				no_idle <= ($urandom_range(0, 3) == 0);
			it = rand_item();
			if ($urandom_range(0, 31) == 0) begin
				it.kind = pipu_pkg::KIND_PALETTE;
			end else begin
				it.kind = pipu_pkg::KIND_PIXEL;
				it.frame_start = (run > SRC_W) && ($urandom_range(0, 3) == 0);
				run = it.frame_start ? 1 : run + 1;
			end
			send_item(it);
		end
		src_valid <= 1'b0;

		// Drain, then allow for the pipeline latency
		while (outstanding != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// Hard limit on run length
	initial begin
		#10_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
